/* hdl/csgf_pkg.sv */
// Shared types, widths and constants for the cubic spline gap filler.
// No dependencies.
package csgf_pkg;

    localparam int SW       = 32;
    localparam int XW       = 48;
    localparam int KW       = 32;
    localparam int AW       = 84;
    localparam int DW       = 30;
    localparam int QW       = 31;
    localparam int RW       = DW + QW;
    localparam int NW       = 7;
    localparam int GW       = 6;
    localparam int MAX_GAP  = 32;

    localparam logic [SW-1:0] SAT_POS = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAT_NEG = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [0:0] {
        REG_GAP_LENGTH    = 1'b0,
        REG_BOUNDARY_MODE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [XW-1:0] p2;
        logic signed [XW-1:0] c;
        logic signed [XW-1:0] a;
        logic signed [XW-1:0] b;
        logic [NW-1:0]        n;
    } item_t;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic [GW-1:0]        step;
        logic                 last;
    } res_t;

endpackage

/* hdl/cubic_spline_gap_fill.sv */
// Top level of the cubic spline gap filler: registers, front, queues, back.
// Depends on csgf_pkg, csgf_fifo, csgf_front and csgf_back.
//
// Use: write gap_length (address 0) and boundary_mode (address 4) over the
// APB port while the block is idle; pready is always high.
// Push one row item (three end samples, three start samples) while full is
// low. For a gap of n points the block returns n values in order on the
// result queue, step_index counting from 1 and last_of_run on the final one.
// Pop a value while empty is low.
// The back loads a row, runs its per-row setup states S_P0 to S_P3, then for
// each value runs the coefficient states S_J0 to S_J2, the multiply-accumulate
// state S_MAC, the rounding state S_DIV0, the restoring divider S_DIV and the
// transfer state S_OUT. A saturating value skips the divider. The back takes
// the next row only after the last value of the current row has gone out.
// The front keeps accepting rows into a two-entry queue while the back works.
// Reset empties both queues and restores gap_length 11, boundary_mode 0.
// A stalled result queue holds the back; the front then fills and raises full.
module cubic_spline_gap_fill #(
    parameter int MAX_GAP = csgf_pkg::MAX_GAP
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           push,
    output logic                           full,
    input  logic signed [csgf_pkg::SW-1:0] end_third_last,
    input  logic signed [csgf_pkg::SW-1:0] end_second_last,
    input  logic signed [csgf_pkg::SW-1:0] end_last,
    input  logic signed [csgf_pkg::SW-1:0] start_first,
    input  logic signed [csgf_pkg::SW-1:0] start_second,
    input  logic signed [csgf_pkg::SW-1:0] start_third,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [csgf_pkg::SW-1:0] fill_value,
    output logic [csgf_pkg::GW-1:0]        step_index,
    output logic                           last_of_run
);
    localparam int IW = $bits(csgf_pkg::item_t);
    localparam int OW = $bits(csgf_pkg::res_t);

    logic [csgf_pkg::GW-1:0] gap_reg;
    logic                    mode_reg;
    logic                    wr_en;
    csgf_pkg::reg_idx_t      reg_idx;

    logic            fq_push, fq_full, fq_pop, fq_empty;
    csgf_pkg::item_t fq_wdata, fq_rdata;
    logic            rq_push, rq_full;
    csgf_pkg::res_t  rq_wdata, rq_rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = csgf_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (reg_idx)
            csgf_pkg::REG_GAP_LENGTH:    prdata = 32'(gap_reg);
            csgf_pkg::REG_BOUNDARY_MODE: prdata = 32'(mode_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg  <= csgf_pkg::GW'(11);
            mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                csgf_pkg::REG_GAP_LENGTH:    gap_reg  <= pwdata[csgf_pkg::GW-1:0];
                csgf_pkg::REG_BOUNDARY_MODE: mode_reg <= pwdata[0];
                default:                     ;
            endcase
        end
    end

    csgf_front #(.MAX_GAP(MAX_GAP)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .p0            (end_third_last),
        .p1            (end_second_last),
        .p2            (end_last),
        .p3            (start_first),
        .p4            (start_second),
        .p5            (start_third),
        .gap_length    (gap_reg),
        .boundary_mode (mode_reg),
        .q_push        (fq_push),
        .q_full        (fq_full),
        .q_item        (fq_wdata)
    );

    csgf_fifo #(.WIDTH(IW), .DEPTH(2)) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .full  (fq_full),
        .wdata (fq_wdata),
        .pop   (fq_pop),
        .empty (fq_empty),
        .rdata (fq_rdata)
    );

    csgf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_pop   (fq_pop),
        .q_empty (fq_empty),
        .q_item  (fq_rdata),
        .r_push  (rq_push),
        .r_full  (rq_full),
        .r_data  (rq_wdata)
    );

    csgf_fifo #(.WIDTH(OW), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .full  (rq_full),
        .wdata (rq_wdata),
        .pop   (pop),
        .empty (empty),
        .rdata (rq_rdata)
    );

    assign fill_value  = rq_rdata.value;
    assign step_index  = rq_rdata.step;
    assign last_of_run = rq_rdata.last;

endmodule

/* hdl/csgf_fifo.sv */
// Small register queue with push/full and pop/empty sides.
// No dependencies.
module csgf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hdl/csgf_front.sv */
// Front end: accepts row samples and forms the spline coefficients.
// Depends on csgf_pkg.
module csgf_front #(
    parameter int MAX_GAP = csgf_pkg::MAX_GAP
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [csgf_pkg::SW-1:0] p0,
    input  logic signed [csgf_pkg::SW-1:0] p1,
    input  logic signed [csgf_pkg::SW-1:0] p2,
    input  logic signed [csgf_pkg::SW-1:0] p3,
    input  logic signed [csgf_pkg::SW-1:0] p4,
    input  logic signed [csgf_pkg::SW-1:0] p5,
    input  logic [csgf_pkg::GW-1:0]     gap_length,
    input  logic                        boundary_mode,
    output logic                        q_push,
    input  logic                        q_full,
    output csgf_pkg::item_t             q_item
);
    localparam int XW = csgf_pkg::XW;
    localparam int NW = csgf_pkg::NW;

    logic                 advance;
    logic                 v1_reg, v2_reg;
    logic signed [XW-1:0] p2_1_reg, c_1_reg, d1_1_reg, d2_1_reg, e1_1_reg, e4_1_reg;
    logic [NW-1:0]        n_1_reg, n_2_reg;
    logic signed [XW-1:0] p2_2_reg, c_2_reg, a_2_reg, inner_2_reg;
    logic [NW-1:0]        n_clamp, m_2;
    logic signed [XW-1:0] x0, x1, x2, x3, x4, x5;

    assign advance = !v2_reg || !q_full;
    assign full    = !advance;
    assign q_push  = v2_reg;

    assign x0 = XW'(p0);
    assign x1 = XW'(p1);
    assign x2 = XW'(p2);
    assign x3 = XW'(p3);
    assign x4 = XW'(p4);
    assign x5 = XW'(p5);

    always_comb
    begin
        if (gap_length == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (NW'(gap_length) > NW'(MAX_GAP))
        begin
            n_clamp = NW'(MAX_GAP);
        end
        else
        begin
            n_clamp = NW'(gap_length);
        end
    end

    assign m_2       = n_2_reg + 1'b1;
    assign q_item.p2 = p2_2_reg;
    assign q_item.c  = c_2_reg;
    assign q_item.a  = a_2_reg;
    assign q_item.b  = XW'(inner_2_reg * $signed({1'b0, m_2})) + XW'(c_2_reg * 12);
    assign q_item.n  = n_2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            p2_1_reg    <= '0;
            c_1_reg     <= '0;
            d1_1_reg    <= '0;
            d2_1_reg    <= '0;
            e1_1_reg    <= '0;
            e4_1_reg    <= '0;
            n_1_reg     <= '0;
            n_2_reg     <= '0;
            p2_2_reg    <= '0;
            c_2_reg     <= '0;
            a_2_reg     <= '0;
            inner_2_reg <= '0;
        end
        else if (advance)
        begin
            v1_reg   <= push;
            p2_1_reg <= x2;
            c_1_reg  <= x3 - x2;
            d1_1_reg <= x2 - x1;
            d2_1_reg <= x4 - x3;
            e1_1_reg <= boundary_mode ? (x0 - 2 * x1 + x2) : '0;
            e4_1_reg <= boundary_mode ? (x3 - 2 * x4 + x5) : '0;
            n_1_reg  <= n_clamp;

            v2_reg      <= v1_reg;
            p2_2_reg    <= p2_1_reg;
            c_2_reg     <= c_1_reg;
            a_2_reg     <= 6 * (d2_1_reg - d1_1_reg) - (e1_1_reg + e4_1_reg);
            inner_2_reg <= -6 * d2_1_reg - 6 * d1_1_reg - (e1_1_reg - e4_1_reg);
            n_2_reg     <= n_1_reg;
        end
    end

endmodule

/* hdl/csgf_back.sv */
// Back end: per-step coefficient sequencer, multiply-accumulate and divider.
// Depends on csgf_pkg.
module csgf_back (
    input  logic            clk,
    input  logic            rst_n,
    output logic            q_pop,
    input  logic            q_empty,
    input  csgf_pkg::item_t q_item,
    output logic            r_push,
    input  logic            r_full,
    output csgf_pkg::res_t  r_data
);
    localparam int XW = csgf_pkg::XW;
    localparam int KW = csgf_pkg::KW;
    localparam int AW = csgf_pkg::AW;
    localparam int DW = csgf_pkg::DW;
    localparam int QW = csgf_pkg::QW;
    localparam int RW = csgf_pkg::RW;
    localparam int NW = csgf_pkg::NW;
    localparam int GW = csgf_pkg::GW;
    localparam int HW = KW / 2;
    localparam int PRW = XW + HW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_P0, S_P1, S_P2, S_P3, S_J0, S_J1, S_J2, S_MAC, S_DIV0, S_DIV, S_OUT
    } state_t;

    state_t                 state_reg;
    csgf_pkg::item_t        item_reg;
    logic [NW-1:0]          m_reg, j_reg;
    logic [13:0]            q1_reg;
    logic [21:0]            q2_reg;
    logic [22:0]            f2_reg;
    logic [25:0]            f1_reg;
    logic [DW-1:0]          den_reg;
    logic signed [KW-1:0]   k1_reg, k2_reg, k3_reg;
    logic signed [15:0]     t_reg;
    logic signed [24:0]     t3_reg;
    logic [2:0]             step_reg;
    logic signed [AW-1:0]   acc_reg;
    logic                   neg_reg, sat_reg;
    logic [RW-1:0]          rem_reg, dsh_reg;
    logic [QW-1:0]          quot_reg;
    logic [4:0]             cnt_reg;

    logic signed [XW-1:0]   mac_x;
    logic signed [KW-1:0]   mac_k;
    logic signed [HW:0]     mac_chunk;
    logic signed [PRW-1:0]  mac_prod;
    logic signed [AW-1:0]   mac_term;
    logic [AW-1:0]          abs_acc, mag;
    logic signed [NW:0]     jm;
    logic signed [NW+1:0]   j2m;
    logic [8:0]             m3p2;

    assign q_pop  = (state_reg == S_IDLE) && !q_empty;
    assign r_push = (state_reg == S_OUT) && !r_full;

    assign jm   = $signed({1'b0, j_reg}) - $signed({1'b0, m_reg});
    assign j2m  = $signed({1'b0, j_reg, 1'b0}) - $signed({2'b0, m_reg});
    assign m3p2 = 9'(m_reg) * 9'd3 + 9'd2;

    always_comb
    begin
        case (step_reg[2:1])
            2'd0:    begin mac_x = item_reg.p2; mac_k = KW'($signed({1'b0, den_reg})); end
            2'd1:    begin mac_x = item_reg.c;  mac_k = k1_reg; end
            2'd2:    begin mac_x = item_reg.a;  mac_k = k2_reg; end
            default: begin mac_x = item_reg.b;  mac_k = k3_reg; end
        endcase
        mac_chunk = step_reg[0] ? $signed({mac_k[KW-1], mac_k[KW-1:HW]})
                                : $signed({1'b0, mac_k[HW-1:0]});
        mac_prod  = PRW'(mac_x) * PRW'(mac_chunk);
        mac_term  = step_reg[0] ? (AW'(mac_prod) <<< HW) : AW'(mac_prod);
    end

    assign abs_acc = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
    assign mag     = abs_acc + AW'(den_reg >> 1);

    always_comb
    begin
        r_data.step = GW'(j_reg);
        r_data.last = (j_reg == item_reg.n);
        if (sat_reg)
        begin
            r_data.value = neg_reg ? csgf_pkg::SAT_NEG : csgf_pkg::SAT_POS;
        end
        else if (neg_reg)
        begin
            r_data.value = -$signed({1'b0, quot_reg});
        end
        else
        begin
            r_data.value = $signed({1'b0, quot_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            item_reg  <= '0;
            m_reg     <= '0;
            j_reg     <= '0;
            q1_reg    <= '0;
            q2_reg    <= '0;
            f2_reg    <= '0;
            f1_reg    <= '0;
            den_reg   <= '0;
            k1_reg    <= '0;
            k2_reg    <= '0;
            k3_reg    <= '0;
            t_reg     <= '0;
            t3_reg    <= '0;
            step_reg  <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            rem_reg   <= '0;
            dsh_reg   <= '0;
            quot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        item_reg  <= q_item;
                        m_reg     <= q_item.n + 1'b1;
                        state_reg <= S_P0;
                    end
                end
                S_P0:
                begin
                    q1_reg    <= 14'(m_reg) * 14'(m_reg + 2'd2);
                    state_reg <= S_P1;
                end
                S_P1:
                begin
                    q2_reg    <= 22'(q1_reg) * 22'(m3p2);
                    f2_reg    <= 23'(q1_reg) * 23'(m_reg) * 23'd3;
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    f1_reg    <= 26'(q2_reg) * 26'd12;
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    den_reg   <= DW'(f1_reg * 33'(m_reg));
                    j_reg     <= NW'(1);
                    state_reg <= S_J0;
                end
                S_J0:
                begin
                    k1_reg    <= KW'(33'(j_reg) * 33'(f1_reg));
                    t_reg     <= 16'($signed({1'b0, j_reg})) * 16'(jm);
                    state_reg <= S_J1;
                end
                S_J1:
                begin
                    k2_reg    <= KW'(40'(t_reg) * $signed({17'b0, f2_reg}));
                    t3_reg    <= 25'(t_reg * 25'(j2m));
                    state_reg <= S_J2;
                end
                S_J2:
                begin
                    k3_reg    <= KW'(-(35'(t3_reg) * $signed({26'b0, m3p2})));
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    acc_reg  <= acc_reg + mac_term;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd7)
                    begin
                        state_reg <= S_DIV0;
                    end
                end
                S_DIV0:
                begin
                    neg_reg  <= acc_reg[AW-1];
                    sat_reg  <= (mag >= (AW'(den_reg) << QW));
                    rem_reg  <= RW'(mag);
                    dsh_reg  <= RW'(den_reg) << (QW - 1);
                    quot_reg <= '0;
                    cnt_reg  <= 5'(QW - 1);
                    state_reg <= (mag >= (AW'(den_reg) << QW)) ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    if (rem_reg >= dsh_reg)
                    begin
                        rem_reg  <= rem_reg - dsh_reg;
                        quot_reg <= {quot_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        quot_reg <= {quot_reg[QW-2:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!r_full)
                    begin
                        if (j_reg == item_reg.n)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_J0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for cubic_spline_gap_fill: row items in, gap values out,
// each value checked against an exact fixed-point spline predictor.
// Depends on csgf_pkg and the cubic_spline_gap_fill RTL.
module tb_top;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int DRAIN_CYCLES   = 200;

    typedef logic signed [127:0] wide_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [2:0]                     paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           push;
    logic                           full;
    logic signed [csgf_pkg::SW-1:0] row [6];
    logic                           empty;
    logic                           pop;
    logic signed [csgf_pkg::SW-1:0] fill_value;
    logic [csgf_pkg::GW-1:0]        step_index;
    logic                           last_of_run;

    csgf_pkg::res_t                 pending_values [$];
    int                             mismatch_count;
    int                             stall_count;
    int                             hold_cycles;
    bit                             quiet;
    logic [csgf_pkg::GW-1:0]        cfg_gap;
    logic                           cfg_mode;

    cubic_spline_gap_fill dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .end_third_last  (row[0]),
        .end_second_last (row[1]),
        .end_last        (row[2]),
        .start_first     (row[3]),
        .start_second    (row[4]),
        .start_third     (row[5]),
        .empty           (empty),
        .pop             (pop),
        .fill_value      (fill_value),
        .step_index      (step_index),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic wide_t widen(longint x);
        wide_t w;
        w = x;
        return w;
    endfunction

    function automatic logic signed [csgf_pkg::SW-1:0] spline_point(longint p [6], longint j,
                                                                    longint n, logic mode);
        longint m, c, d1, d2, e1, e4, a, b, den;
        wide_t  num, mag, q;
        m  = n + 1;
        e1 = 0;
        e4 = 0;
        if (mode)
        begin
            e1 = p[0] - 2 * p[1] + p[2];
            e4 = p[3] - 2 * p[4] + p[5];
        end
        c   = p[3] - p[2];
        d1  = p[2] - p[1];
        d2  = p[4] - p[3];
        a   = 6 * (d2 - d1) - (e1 + e4);
        b   = m * (-6 * d2 - 6 * d1 - (e1 - e4)) + 12 * c;
        den = 12 * m * m * (m + 2) * (3 * m + 2);
        num = widen(p[2]) * widen(den)
            + widen(c) * widen(j * 12 * m * (m + 2) * (3 * m + 2))
            + widen(a) * widen(j * (j - m) * 3 * m * m * (m + 2))
            - widen(b) * widen(j * (2 * j - m) * (j - m) * (3 * m + 2));
        mag = (num < 0) ? -num : num;
        q   = (mag + widen(den / 2)) / widen(den);
        if (num < 0)
            return (q >= widen(64'sh80000000)) ? csgf_pkg::SAT_NEG : csgf_pkg::SW'(-q);
        return (q > widen(64'sh7FFFFFFF)) ? csgf_pkg::SAT_POS : csgf_pkg::SW'(q);
    endfunction

    function automatic void predict_gap();
        longint         p [6];
        longint         n;
        csgf_pkg::res_t r;
        foreach (p[i])
            p[i] = row[i];
        n = cfg_gap;
        if (n < 1)
            n = 1;
        if (n > csgf_pkg::MAX_GAP)
            n = csgf_pkg::MAX_GAP;
        for (longint j = 1; j <= n; j++)
        begin
            r.value = spline_point(p, j, n, cfg_mode);
            r.step  = csgf_pkg::GW'(j);
            r.last  = (j == n);
            pending_values.push_back(r);
        end
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        csgf_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_values.size() == 0)
            begin
                report("unexpected transfer, step", step_index, 0);
            end
            else
            begin
                want = pending_values.pop_front();
                if (fill_value !== want.value)
                    report("fill_value", fill_value, want.value);
                if (step_index !== want.step)
                    report("step_index", step_index, want.step);
                if (last_of_run !== want.last)
                    report("last_of_run", last_of_run, want.last);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            pop = 1'b0;
        end
        else
        begin
            pop = quiet || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            stall_count = 0;
        else
            stall_count = stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(csgf_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == csgf_pkg::REG_GAP_LENGTH)
            cfg_gap = value[csgf_pkg::GW-1:0];
        else
            cfg_mode = value[0];
    endtask

    task automatic wait_idle();
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [31:0] gap, logic mode);
        wait_idle();
        reg_write(csgf_pkg::REG_GAP_LENGTH, gap);
        reg_write(csgf_pkg::REG_BOUNDARY_MODE, {$urandom() & 32'hFFFF_FFFE} | mode);
    endtask

    // one row transfer; push stays high into the next call
    task automatic send_row(logic signed [csgf_pkg::SW-1:0] s [6]);
        bit done;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(99) < 8)
            begin
                push = 1'b0;
            end
            else
            begin
                push = 1'b1;
                foreach (row[i])
                    row[i] = s[i];
                @(posedge clk);
                if (!full)
                begin
                    predict_gap();
                    done = 1'b1;
                end
            end
        end
    endtask

    task automatic end_push();
        @(negedge clk);
        push = 1'b0;
    endtask

    function automatic logic signed [csgf_pkg::SW-1:0] rand_sample(
        int style, logic signed [csgf_pkg::SW-1:0] base);
        case (style)
            0:       return $urandom();
            1:       return base + $signed($urandom_range(4095)) - 2048;
            2:       return base + $signed($urandom_range(32'h3FFFF)) - 32'sh20000;
            default: return ($urandom_range(1)) ? csgf_pkg::SAT_POS : csgf_pkg::SAT_NEG;
        endcase
    endfunction

    task automatic send_random_row();
        logic signed [csgf_pkg::SW-1:0] s [6];
        logic signed [csgf_pkg::SW-1:0] base;
        int style;
        style = $urandom_range(99);
        style = (style < 25) ? 0 : (style < 60) ? 1 : (style < 95) ? 2 : 3;
        base  = $urandom();
        if (style != 0)
            base = base >>> $urandom_range(12);
        foreach (s[i])
            s[i] = rand_sample(style, base + $signed(i * $urandom_range(200000)));
        send_row(s);
    endtask

    task automatic test_extremes();
        logic signed [csgf_pkg::SW-1:0] s [6];
        configure(1, 1'b0);
        s = '{csgf_pkg::SAT_POS, csgf_pkg::SAT_POS, csgf_pkg::SAT_POS,
              csgf_pkg::SAT_POS, csgf_pkg::SAT_POS, csgf_pkg::SAT_POS};
        send_row(s);
        s = '{csgf_pkg::SAT_NEG, csgf_pkg::SAT_NEG, csgf_pkg::SAT_NEG,
              csgf_pkg::SAT_NEG, csgf_pkg::SAT_NEG, csgf_pkg::SAT_NEG};
        send_row(s);
        end_push();
        configure(32, 1'b1);
        s = '{csgf_pkg::SAT_NEG, csgf_pkg::SAT_POS, csgf_pkg::SAT_NEG,
              csgf_pkg::SAT_POS, csgf_pkg::SAT_NEG, csgf_pkg::SAT_POS};
        send_row(s);
        s = '{csgf_pkg::SAT_POS, csgf_pkg::SAT_NEG, csgf_pkg::SAT_POS,
              csgf_pkg::SAT_NEG, csgf_pkg::SAT_POS, csgf_pkg::SAT_NEG};
        send_row(s);
        s = '{0, 0, 0, 0, 0, 0};
        send_row(s);
        end_push();
    endtask

    task automatic test_gap_limits();
        logic signed [csgf_pkg::SW-1:0] s [6];
        s = '{32'sh10000, 32'sh20000, 32'sh30000, -32'sh30000, -32'sh20000, 32'sh8000};
        configure(0, 1'b0);
        send_row(s);
        send_row(s);
        end_push();
        configure(63, 1'b1);
        send_row(s);
        end_push();
        configure(33, 1'b0);
        send_row(s);
        end_push();
        configure(11, 1'b1);
        send_row(s);
        send_random_row();
        send_random_row();
        end_push();
        configure(32'hFFFF_FFC2, 1'b0);
        send_row(s);
        end_push();
    endtask

    task automatic test_random_rows();
        int gap;
        for (int phase = 0; phase < 19; phase++)
        begin
            gap = ($urandom_range(99) < 6) ? 32 : $urandom_range(8, 1);
            configure(gap, 1'($urandom_range(1)));
            quiet = (phase == 7);
            repeat (20) send_random_row();
            end_push();
            quiet = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        configure(4, 1'b1);
        wait (pop == 1'b0 || pop == 1'b1);
        @(negedge clk);
        hold_cycles = 3000;
        repeat (12) send_random_row();
        end_push();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        push           = 1'b0;
        pop            = 1'b0;
        foreach (row[i])
            row[i] = '0;
        mismatch_count = 0;
        stall_count    = 0;
        hold_cycles    = 0;
        quiet          = 1'b0;
        cfg_gap        = 6'd11;
        cfg_mode       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_gap_limits();
        test_backpressure();
        test_random_rows();

        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hdl/csgf_pkg.sv
hdl/csgf_fifo.sv
hdl/csgf_front.sv
hdl/csgf_back.sv
hdl/cubic_spline_gap_fill.sv
sim/tb_top.sv
